### rtl/core/ipv4p_pkg.sv
// Package for the IPv4 prefix text parser.
// Field widths and character codes; no dependencies.
`timescale 1ns / 1ps

package ipv4p_pkg;

  localparam int CHAR_W = 8;
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;

  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] MAX_DOTS = 2'd3;

  localparam logic [8:0] OCTET_MAX = 9'd255;
  localparam logic [8:0] OCTET_SAT = 9'd256;
  localparam logic [5:0] LEN_MAX   = 6'd32;
  localparam logic [5:0] LEN_SAT   = 6'd33;

endpackage

### rtl/core/ipv4p_text_if.sv
// Input channel for the IPv4 prefix text parser: one text character per item.
// Depends on ipv4p_pkg.
`timescale 1ns / 1ps

interface ipv4p_text_if;
  logic                            valid;
  logic                            ready;
  logic [ipv4p_pkg::CHAR_W-1:0]    char_code;
  logic                            end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

### rtl/core/ipv4p_result_if.sv
// Output channel for the IPv4 prefix text parser: one parsed prefix per item.
// Depends on ipv4p_pkg.
`timescale 1ns / 1ps

interface ipv4p_result_if;
  logic                            valid;
  logic                            ready;
  logic [ipv4p_pkg::ADDR_W-1:0]    address;
  logic [ipv4p_pkg::LEN_W-1:0]     prefix_length;
  logic                            status;

  modport source (output valid, output address, output prefix_length, output status,
                  input ready);
  modport sink   (input valid, input address, input prefix_length, input status,
                  output ready);
endinterface

### rtl/core/ipv4_prefix_text_parser_top.sv
// IPv4 prefix text parser, top level.
// Depends on ipv4p_pkg, ipv4p_text_if and ipv4p_result_if.
//
// Usage:
//   text   : one ASCII character per item ('0'..'9', '.', '/'), with
//            end_of_text set on the last character of a prefix.
//   result : one item per text, issued for the character carrying
//            end_of_text: address (first octet in bits 31:24),
//            prefix_length and status (1 = malformed; address and
//            length are then zero).
//   One character is taken per cycle unless an end-of-text character waits
//   (see below). The parse state is updated in the cycle of acceptance; the
//   result register shows it in the cycle after the last character is taken.
//   A result waiting in the output register does not block characters that
//   produce no result; an end-of-text character waits only while the output
//   register is full and not being taken.
//   Reset (rst, synchronous) clears the parse state and empties the output
//   register. After each result the parse state returns to its reset value.
`timescale 1ns / 1ps

module ipv4_prefix_text_parser_top (
  input  logic                  clk,
  input  logic                  rst,
  ipv4p_text_if.sink            text,
  ipv4p_result_if.source        result
);
  import ipv4p_pkg::*;

  logic [8:0]        octet_acc;
  logic [1:0]        dots_seen;
  logic [ADDR_W-1:0] addr_acc;
  logic [LEN_W-1:0]  len_acc;
  logic              in_len;
  logic              digit_in_field;
  logic              malformed;

  logic [8:0]        octet_acc_next;
  logic [1:0]        dots_seen_next;
  logic [ADDR_W-1:0] addr_acc_next;
  logic [LEN_W-1:0]  len_acc_next;
  logic              in_len_next;
  logic              digit_in_field_next;
  logic              malformed_next;

  logic [ADDR_W-1:0] res_address;
  logic [LEN_W-1:0]  res_length;
  logic              res_status;

  logic              out_valid;
  logic [ADDR_W-1:0] out_address;
  logic [LEN_W-1:0]  out_length;
  logic              out_status;

  logic              accept;

  function automatic logic [ADDR_W-1:0] place_octet(input logic [ADDR_W-1:0] addr,
                                                    input logic [8:0] octet,
                                                    input logic [1:0] dots);
    logic [ADDR_W-1:0] r;
    r = addr;
    unique case (dots)
      2'd0: r[31:24] = r[31:24] | octet[7:0];
      2'd1: r[23:16] = r[23:16] | octet[7:0];
      2'd2: r[15:8]  = r[15:8]  | octet[7:0];
      2'd3: r[7:0]   = r[7:0]   | octet[7:0];
      default: r = addr;
    endcase
    return r;
  endfunction

  assign text.ready = !out_valid || result.ready || !text.end_of_text;
  assign accept     = text.valid && text.ready;

  always_comb begin
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] oct_prod;
    logic [9:0]  len_prod;
    logic        mal_end;
    logic [2:0]  fields;

    is_digit = (text.char_code >= CHAR_ZERO) && (text.char_code <= CHAR_NINE);
    digit    = text.char_code[3:0];
    oct_prod = 12'({3'b000, octet_acc} * 12'd10) + 12'(digit);
    len_prod = 10'({4'b0000, len_acc} * 10'd10) + 10'(digit);

    octet_acc_next      = octet_acc;
    dots_seen_next      = dots_seen;
    addr_acc_next       = addr_acc;
    len_acc_next        = len_acc;
    in_len_next         = in_len;
    digit_in_field_next = digit_in_field;
    malformed_next      = malformed;

    priority if (is_digit) begin
      if (in_len) begin
        if (len_prod > 10'(LEN_MAX)) begin
          malformed_next = 1'b1;
          len_acc_next   = LEN_SAT;
        end else begin
          len_acc_next = len_prod[LEN_W-1:0];
        end
      end else begin
        if (oct_prod > 12'(OCTET_MAX)) begin
          malformed_next = 1'b1;
          octet_acc_next = OCTET_SAT;
        end else begin
          octet_acc_next = oct_prod[8:0];
        end
      end
      digit_in_field_next = 1'b1;
    end else if (text.char_code == CHAR_DOT) begin
      if (in_len || !digit_in_field || dots_seen == MAX_DOTS) begin
        malformed_next = 1'b1;
      end else begin
        addr_acc_next       = place_octet(addr_acc, octet_acc, dots_seen);
        dots_seen_next      = dots_seen + 2'd1;
        octet_acc_next      = '0;
        digit_in_field_next = 1'b0;
      end
    end else if (text.char_code == CHAR_SLASH) begin
      if (in_len || !digit_in_field) begin
        malformed_next = 1'b1;
      end else begin
        addr_acc_next       = place_octet(addr_acc, octet_acc, dots_seen);
        octet_acc_next      = '0;
        in_len_next         = 1'b1;
        digit_in_field_next = 1'b0;
      end
    end else begin
      malformed_next = 1'b1;
    end

    // end-of-text evaluation on the updated state
    mal_end = malformed_next || !digit_in_field_next;
    fields  = {1'b0, dots_seen_next} + 3'd1;
    if (in_len_next) begin
      res_address = addr_acc_next;
      res_length  = len_acc_next;
    end else begin
      res_address = digit_in_field_next ?
                    place_octet(addr_acc_next, octet_acc_next, dots_seen_next) :
                    addr_acc_next;
      res_length  = {fields, 3'b000};
    end
    res_status = mal_end;
    if (mal_end) begin
      res_address = '0;
      res_length  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octet_acc      <= '0;
      dots_seen      <= '0;
      addr_acc       <= '0;
      len_acc        <= '0;
      in_len         <= 1'b0;
      digit_in_field <= 1'b0;
      malformed      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept && text.end_of_text) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (text.end_of_text) begin
          octet_acc      <= '0;
          dots_seen      <= '0;
          addr_acc       <= '0;
          len_acc        <= '0;
          in_len         <= 1'b0;
          digit_in_field <= 1'b0;
          malformed      <= 1'b0;
        end else begin
          octet_acc      <= octet_acc_next;
          dots_seen      <= dots_seen_next;
          addr_acc       <= addr_acc_next;
          len_acc        <= len_acc_next;
          in_len         <= in_len_next;
          digit_in_field <= digit_in_field_next;
          malformed      <= malformed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.end_of_text) begin
      out_address <= res_address;
      out_length  <= res_length;
      out_status  <= res_status;
    end
  end

  assign result.valid         = out_valid;
  assign result.address       = out_address;
  assign result.prefix_length = out_length;
  assign result.status        = out_status;

endmodule

### sim/tb_ipv4_prefix_text_parser_top.sv
// Testbench for ipv4_prefix_text_parser_top: drives prefix text one character per item and
// checks every parsed prefix against a cycle-free model of the parser.
// Depends on ipv4p_pkg, ipv4p_text_if, ipv4p_result_if and the parser RTL.
`timescale 1ns / 1ps

module tb_ipv4_prefix_text_parser_top;
  import ipv4p_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_length;
    logic              status;
  } prefix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipv4p_text_if   text_ch ();
  ipv4p_result_if res_ch ();

  ipv4_prefix_text_parser_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch)
  );

  always #5 clk = ~clk;

  // parser model state
  logic [8:0]        m_octet;
  logic [1:0]        m_dots;
  logic [ADDR_W-1:0] m_addr;
  logic [LEN_W-1:0]  m_len;
  logic              m_in_len;
  logic              m_digit;
  logic              m_bad;

  prefix_t pending_prefixes[$];
  logic [CHAR_W-1:0] text_buf[$];

  int  errors      = 0;
  int  sent_chars  = 0;
  int  idle_cycles = 0;
  int  hold_token  = 0;
  bit  tx_gaps_on  = 1'b1;
  bit  rx_gaps_on  = 1'b1;

  function automatic void clear_parser();
    m_octet  = '0;
    m_dots   = '0;
    m_addr   = '0;
    m_len    = '0;
    m_in_len = 1'b0;
    m_digit  = 1'b0;
    m_bad    = 1'b0;
  endfunction

  function automatic void place_octet();
    m_addr = m_addr | (ADDR_W'(m_octet[7:0]) << (8 * (int'(MAX_DOTS) - int'(m_dots))));
  endfunction

  // Returns 1 when the character closes a text; res then holds the parsed prefix.
  function automatic bit parse_char(input logic [CHAR_W-1:0] c, input bit eot,
                                    output prefix_t res);
    int v;
    logic [LEN_W-1:0] len;
    res = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (m_in_len) begin
        v = int'(m_len) * 10 + (int'(c) - int'(CHAR_ZERO));
        if (v > int'(LEN_MAX)) begin
          m_bad = 1'b1;
          v = int'(LEN_SAT);
        end
        m_len = LEN_W'(v);
      end else begin
        v = int'(m_octet) * 10 + (int'(c) - int'(CHAR_ZERO));
        if (v > int'(OCTET_MAX)) begin
          m_bad = 1'b1;
          v = int'(OCTET_SAT);
        end
        m_octet = 9'(v);
      end
      m_digit = 1'b1;
    end else if (c == CHAR_DOT) begin
      if (m_in_len || !m_digit || m_dots >= MAX_DOTS) begin
        m_bad = 1'b1;
      end else begin
        place_octet();
        m_dots  = m_dots + 2'd1;
        m_octet = '0;
        m_digit = 1'b0;
      end
    end else if (c == CHAR_SLASH) begin
      if (m_in_len || !m_digit) begin
        m_bad = 1'b1;
      end else begin
        place_octet();
        m_octet  = '0;
        m_in_len = 1'b1;
        m_digit  = 1'b0;
      end
    end else begin
      m_bad = 1'b1;
    end

    if (!eot) return 1'b0;

    if (!m_digit) m_bad = 1'b1;
    if (m_in_len) begin
      len = m_len;
    end else begin
      if (m_digit) place_octet();
      len = LEN_W'(8 * (int'(m_dots) + 1));
    end
    if (m_bad) begin
      res.status = 1'b1;
    end else begin
      res.address       = m_addr;
      res.prefix_length = len;
    end
    clear_parser();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result check, prediction and watchdog
  always @(posedge clk) begin
    prefix_t want;
    prefix_t got;
    bit in_acc;
    bit out_acc;
    in_acc  = !rst && text_ch.valid && text_ch.ready;
    out_acc = !rst && res_ch.valid && res_ch.ready;
    if (out_acc) begin
      got.address       = res_ch.address;
      got.prefix_length = res_ch.prefix_length;
      got.status        = res_ch.status;
      if (pending_prefixes.size() == 0) begin
        report_mismatch("result with nothing pending", got.address, '0);
      end else begin
        want = pending_prefixes.pop_front();
        if (got.address !== want.address)
          report_mismatch("address", got.address, want.address);
        if (got.prefix_length !== want.prefix_length)
          report_mismatch("prefix_length", 32'(got.prefix_length), 32'(want.prefix_length));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
    if (rst) begin
      clear_parser();
    end else if (in_acc) begin
      if (parse_char(text_ch.char_code, text_ch.end_of_text, want))
        pending_prefixes.push_back(want);
    end
    if (rst || in_acc || out_acc) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random ready, plus long hold-offs on request
  initial begin : result_sink
    int busy;
    int seen;
    res_ch.ready = 1'b0;
    busy = 0;
    seen = 0;
    forever begin
      @(negedge clk);
      if (hold_token != seen) begin
        seen = hold_token;
        busy = HOLD_CYCLES;
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (busy > 0) begin
        res_ch.ready <= 1'b0;
        busy--;
      end else begin
        res_ch.ready <= 1'b1;
        busy = pick_gap(rx_gaps_on);
      end
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] c, bit eot);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      @(negedge clk);
      text_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    text_ch.valid       <= 1'b1;
    text_ch.char_code   <= c;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!text_ch.ready);
    sent_chars++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text_buf();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic push_number(int v, int zeros);
    string s;
    s = $sformatf("%0d", v);
    repeat (zeros) text_buf.push_back(CHAR_ZERO);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic int pick_zeros();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  task automatic build_prefix_text(bit allow_damage);
    int n;
    int r;
    int pos;
    bit has_slash;
    text_buf.delete();
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      if (k > 0) text_buf.push_back(CHAR_DOT);
      r = $urandom_range(0, 7);
      push_number((r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255), pick_zeros());
    end
    has_slash = 1'($urandom_range(0, 1));
    if (has_slash) begin
      text_buf.push_back(CHAR_SLASH);
      r = $urandom_range(0, 5);
      push_number((r == 0) ? 0 : (r == 1) ? 32 : $urandom_range(0, 32), pick_zeros());
    end
    if (!allow_damage || $urandom_range(0, 99) >= 30) return;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 7))
      0: text_buf[pos] = CHAR_W'($urandom_range(0, 255));
      1: text_buf.insert(pos, CHAR_DOT);
      2: text_buf.insert(pos, CHAR_SLASH);
      3: if (text_buf.size() > 1) text_buf.delete(pos);
      4: begin
        text_buf.push_back(CHAR_DOT);
        push_number($urandom_range(0, 255), 0);
      end
      5: begin
        r = $urandom_range(256, 999);
        for (int i = 0; i < 3; i++) begin
          text_buf.push_front(CHAR_ZERO + CHAR_W'(r % 10));
          r = r / 10;
        end
      end
      6: begin
        if (!has_slash) text_buf.push_back(CHAR_SLASH);
        push_number($urandom_range(33, 99), pick_zeros());
      end
      default: text_buf.push_back(CHAR_DOT);
    endcase
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (pending_prefixes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_directed();
    send_string("1.2.3.4/24");
    send_string("9/0");
    send_string("10.1");
    send_string("256");
    send_string("1/33");
    send_string(".");
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_wellformed_texts(int n_chars);
    int stop;
    stop = sent_chars + n_chars;
    while (sent_chars < stop) begin
      build_prefix_text(1'b1);
      send_text_buf();
    end
  endtask

  task automatic test_noise_texts(int n_chars);
    string charset;
    int stop;
    int n;
    charset = "0123456789./";
    stop = sent_chars + n_chars;
    while (sent_chars < stop) begin
      text_buf.delete();
      n = $urandom_range(1, 5);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        else text_buf.push_back(charset[$urandom_range(0, charset.len() - 1)]);
      end
      send_text_buf();
    end
  endtask

  task automatic test_back_to_back(int n_chars);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    test_wellformed_texts(n_chars);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // results pile up behind a long hold-off until the input stalls
  task automatic test_output_stall();
    tx_gaps_on = 1'b0;
    hold_token++;
    repeat (30) begin
      build_prefix_text(1'b0);
      send_text_buf();
    end
    tx_gaps_on = 1'b1;
    wait_results_drained();
  endtask

  initial begin
    text_ch.valid       = 1'b0;
    text_ch.char_code   = '0;
    text_ch.end_of_text = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_wellformed_texts(500);
    test_output_stall();
    test_noise_texts(250);
    wait_results_drained();
    test_back_to_back(250);
    test_wellformed_texts(250);

    wait_results_drained();
    repeat (5) @(posedge clk);
    if (pending_prefixes.size() != 0)
      report_mismatch("results never arrived", pending_prefixes.size(), 0);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ipv4p_pkg.sv
rtl/core/ipv4p_text_if.sv
rtl/core/ipv4p_result_if.sv
rtl/core/ipv4_prefix_text_parser_top.sv
sim/tb_ipv4_prefix_text_parser_top.sv
